// File: design/jsu_pkg.sv
// ============================================================================
// jsu_pkg
// Shared types, character codes and helpers for the JSON string unescaper.
// ============================================================================
package jsu_pkg;

    localparam int MAX_RES = 8;
    localparam int SLOT_W  = 3;
    localparam int CNT_W   = 4;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] len_t;

    // Character codes
    localparam byte_t CH_NUL    = 8'h00;
    localparam byte_t CH_QUOTE  = 8'h22;
    localparam byte_t CH_BSLASH = 8'h5C;
    localparam byte_t CH_U      = 8'h75;
    localparam byte_t CH_N      = 8'h6E;
    localparam byte_t CH_T      = 8'h74;
    localparam byte_t CH_R      = 8'h72;
    localparam byte_t CH_B      = 8'h62;
    localparam byte_t CH_F      = 8'h66;
    localparam byte_t CH_LF     = 8'h0A;
    localparam byte_t CH_TAB    = 8'h09;
    localparam byte_t CH_CR     = 8'h0D;
    localparam byte_t CH_BS     = 8'h08;
    localparam byte_t CH_FF     = 8'h0C;

    // UTF-8 lead and continuation marks
    localparam byte_t UTF8_LEAD2 = 8'hC0;
    localparam byte_t UTF8_LEAD3 = 8'hE0;
    localparam byte_t UTF8_LEAD4 = 8'hF0;
    localparam byte_t UTF8_CONT  = 8'h80;

    localparam logic [15:0] SUR_HI_LO = 16'hD800;
    localparam logic [15:0] SUR_HI_HI = 16'hDBFF;
    localparam logic [15:0] SUR_LO_LO = 16'hDC00;
    localparam logic [15:0] SUR_LO_HI = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    // One queue entry: the results caused by one input byte
    typedef struct packed {
        byte_t [MAX_RES-1:0] bytes;
        logic [CNT_W-1:0]    count;
        logic                is_end;
        len_t                base;
    } entry_t;

    typedef struct packed {
        logic [2:0]  len;
        byte_t [3:0] b;
    } utf8_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t r;
        r.b = '0;
        if (cp <= 21'h7F) begin
            r.len  = 3'd1;
            r.b[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            r.len  = 3'd2;
            r.b[0] = UTF8_LEAD2 | {3'b0, cp[10:6]};
            r.b[1] = UTF8_CONT | {2'b0, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            r.len  = 3'd3;
            r.b[0] = UTF8_LEAD3 | {4'b0, cp[15:12]};
            r.b[1] = UTF8_CONT | {2'b0, cp[11:6]};
            r.b[2] = UTF8_CONT | {2'b0, cp[5:0]};
        end else begin
            r.len  = 3'd4;
            r.b[0] = UTF8_LEAD4 | {5'b0, cp[20:18]};
            r.b[1] = UTF8_CONT | {2'b0, cp[17:12]};
            r.b[2] = UTF8_CONT | {2'b0, cp[11:6]};
            r.b[3] = UTF8_CONT | {2'b0, cp[5:0]};
        end
        return r;
    endfunction

    function automatic hex_t hex_digit(input byte_t c);
        hex_t r;
        r.ok  = 1'b1;
        r.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.val = 4'(c - 8'h37);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    function automatic byte_t esc_map(input byte_t c);
        byte_t r;
        case (c)
            CH_N:    r = CH_LF;
            CH_T:    r = CH_TAB;
            CH_R:    r = CH_CR;
            CH_B:    r = CH_BS;
            CH_F:    r = CH_FF;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

// File: design/jsu_if.sv
// ============================================================================
// jsu_if
// Valid/ready channels for text bytes in and decoded results out.
// ============================================================================
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface jsu_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        kind;
    logic [15:0] out_length;
    logic        last;

    modport source (output valid, output out_byte, output kind, output out_length,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input out_length,
                    input last, output ready);
endinterface

// File: design/json_string_unescape_utf8_core.sv
// ============================================================================
// json_string_unescape_utf8_core
// Unescapes a JSON string body into UTF-8 bytes with a length result at end.
// ============================================================================
//
//  Channel   Direction  Transfer content
//  --------  ---------  ---------------------------------------------------
//  text      in         text_byte: one byte of the string body
//  result    out        out_byte, kind, out_length, last: one result
//  cfg       in         cfg_wen/cfg_wdata: out_capacity write, no handshake
//
//  Cycles: the decoder takes one text byte per cycle whenever the entry queue
//  has room. The serializer delivers one result per cycle while the sink does
//  not stall it, so a byte that yields n results (up to 7) holds the output
//  side until all of them transfer. The queue entry is written at the transfer
//  edge, and the output register then loads each result from the queue head.
//  Reset: normal text mode, count zero, out_capacity 256, queue empty.
//  Stalls: text.ready drops while QUEUE_DEPTH entries wait; a stalled result
//  holds in the output register while the decoder keeps going.
//
module json_string_unescape_utf8_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    jsu_in_if.sink        text,
    jsu_out_if.source     result,
    input  logic          cfg_wen,
    input  jsu_pkg::len_t cfg_wdata
);
    import jsu_pkg::*;

    entry_t q_in, q_head;
    logic   q_push, q_pop, q_empty, q_full;

    // Front: classify bytes and pack each byte's results into one entry
    jsu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    // Queue: decouple the byte intake from the result serializer
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Back: advance through the head entry one result per transfer
    jsu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

// File: design/jsu_queue.sv
// ============================================================================
// jsu_queue
// Small FIFO of result entries between the decoder front and the serializer.
// ============================================================================
module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  jsu_pkg::entry_t push_data,
    input  logic            pop,
    output jsu_pkg::entry_t head,
    output logic            empty,
    output logic            full
);
    import jsu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    entry_t           slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    cnt_reg;

    assign head  = slots[rd_ptr_reg];
    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == CW'(DEPTH));

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/jsu_front.sv
// ============================================================================
// jsu_front
// Escape decoder: takes one text byte a cycle while the queue is not full,
// tracks escape state and the written count, and packs the results of each
// byte into one queue entry.
module jsu_front (
    input  logic            clk,
    input  logic            rst_n,
    jsu_in_if.sink          text,
    input  logic            cfg_wen,
    input  jsu_pkg::len_t   cfg_wdata,
    input  logic            q_full,
    output logic            q_push,
    output jsu_pkg::entry_t q_data
);
    import jsu_pkg::*;

    localparam logic [2:0] M_NORMAL  = 3'd0;
    localparam logic [2:0] M_ESC     = 3'd1;
    localparam logic [2:0] M_HEX     = 3'd2;
    localparam logic [2:0] M_HI_WAIT = 3'd3;
    localparam logic [2:0] M_HI_BS   = 3'd4;
    localparam logic [2:0] M_HI_HEX  = 3'd5;

    localparam len_t CAP_RESET = 16'd256;

    logic [2:0]  mode_reg, mode_next;
    logic [15:0] hex_reg, hex_next;
    logic [1:0]  dig_reg, dig_next;
    byte_t       dbyte_reg [0:2];
    byte_t       dbyte_next [0:2];
    logic [15:0] pend_reg, pend_next;
    len_t        wr_reg, wr_next;
    len_t        cap_reg;

    logic        accept;
    byte_t       b;
    hex_t        hd;
    logic [15:0] hv4;
    logic        nb_end, nb_esc, nb_lit;
    logic        hv4_high, hv4_low;

    logic        g1_on, g2_on, end_on;
    logic [20:0] g2_cp;
    byte_t       s_bytes [0:3];
    logic [2:0]  s_n;

    utf8_t       g1u, g2u;
    logic [16:0] w0, w1, w2, w3, cap17;
    logic        f1, f2;
    logic [2:0]  l2, sk, o1, o2, rel1, rel2;
    logic [3:0]  n_data;

    assign accept   = text.valid && text.ready;
    assign text.ready = !q_full;
    assign b        = text.text_byte;
    assign hd       = hex_digit(b);
    assign hv4      = {hex_reg[11:0], hd.val};
    assign hv4_high = (hv4 >= SUR_HI_LO) && (hv4 <= SUR_HI_HI);
    assign hv4_low  = (hv4 >= SUR_LO_LO) && (hv4 <= SUR_LO_HI);
    assign nb_end   = (b == CH_NUL) || (b == CH_QUOTE);
    assign nb_esc   = (b == CH_BSLASH);
    assign nb_lit   = !nb_end && !nb_esc;

    // Escape state machine: decide which groups this byte produces
    always_comb
    begin
        mode_next = mode_reg;
        hex_next  = hex_reg;
        dig_next  = dig_reg;
        pend_next = pend_reg;
        for (int k = 0; k < 3; k++)
        begin
            dbyte_next[k] = dbyte_reg[k];
        end
        g1_on  = 1'b0;
        g2_on  = 1'b0;
        g2_cp  = '0;
        end_on = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            s_bytes[k] = b;
        end
        s_n = 3'd0;

        case (mode_reg)
            M_ESC, M_HI_BS:
            begin
                if (mode_reg == M_HI_BS && b == CH_U)
                begin
                    mode_next = M_HI_HEX;
                    hex_next  = '0;
                    dig_next  = '0;
                end
                else
                begin
                    // An escape other than \u after a high surrogate flushes it first
                    g1_on     = (mode_reg == M_HI_BS);
                    mode_next = M_NORMAL;
                    if (b == CH_NUL)
                    begin
                        s_bytes[0] = CH_BSLASH;
                        s_n        = 3'd1;
                        end_on     = 1'b1;
                    end
                    else if (b == CH_U)
                    begin
                        mode_next = M_HEX;
                        hex_next  = '0;
                        dig_next  = '0;
                    end
                    else
                    begin
                        s_bytes[0] = esc_map(b);
                        s_n        = 3'd1;
                    end
                end
            end
            M_HEX, M_HI_HEX:
            begin
                if (hd.ok)
                begin
                    if (dig_reg == 2'd3)
                    begin
                        hex_next = '0;
                        dig_next = '0;
                        if (mode_reg == M_HI_HEX && hv4_low)
                        begin
                            mode_next = M_NORMAL;
                            g2_on     = 1'b1;
                            g2_cp     = SUPP_BASE + {1'b0, pend_reg[9:0], hv4[9:0]};
                        end
                        else
                        begin
                            g1_on = (mode_reg == M_HI_HEX);
                            if (hv4_high)
                            begin
                                pend_next = hv4;
                                mode_next = M_HI_WAIT;
                            end
                            else
                            begin
                                mode_next = M_NORMAL;
                                g2_on     = 1'b1;
                                g2_cp     = {5'b0, hv4};
                            end
                        end
                    end
                    else
                    begin
                        hex_next            = hv4;
                        dig_next            = dig_reg + 2'd1;
                        dbyte_next[dig_reg] = b;
                    end
                end
                else
                begin
                    // Bad digit: drop the \u, replay collected digits, then
                    // treat the byte as plain text
                    g1_on    = (mode_reg == M_HI_HEX);
                    hex_next = '0;
                    dig_next = '0;
                    for (int k = 0; k < 3; k++)
                    begin
                        s_bytes[k] = dbyte_reg[k];
                    end
                    s_bytes[dig_reg] = b;
                    s_n       = {1'b0, dig_reg} + {2'b0, nb_lit};
                    mode_next = nb_esc ? M_ESC : M_NORMAL;
                    end_on    = nb_end;
                end
            end
            M_HI_WAIT:
            begin
                if (nb_esc)
                begin
                    mode_next = M_HI_BS;
                end
                else
                begin
                    g1_on     = 1'b1;
                    mode_next = M_NORMAL;
                    s_n       = {2'b0, nb_lit};
                    end_on    = nb_end;
                end
            end
            default:
            begin
                mode_next = nb_esc ? M_ESC : M_NORMAL;
                s_n       = {2'b0, nb_lit};
                end_on    = nb_end;
            end
        endcase

        if (end_on)
        begin
            mode_next = M_NORMAL;
            hex_next  = '0;
            dig_next  = '0;
            pend_next = '0;
        end
    end

    // Capacity checks and packing of the result bytes into the entry
    always_comb
    begin
        g1u   = utf8_encode({5'b0, pend_reg});
        g2u   = utf8_encode(g2_cp);
        w0    = {1'b0, wr_reg};
        cap17 = {1'b0, cap_reg};

        f1 = g1_on && ((w0 + 17'd3) < cap17);
        w1 = f1 ? (w0 + 17'd3) : w0;
        l2 = g2_on ? g2u.len : 3'd0;
        f2 = g2_on && ((w1 + 17'(l2)) < cap17);
        w2 = f2 ? (w1 + 17'(l2)) : w1;

        // Single bytes each take one place while room remains
        sk = 3'd0;
        for (int k = 1; k <= 4; k++)
        begin
            if ((3'(k) <= s_n) && ((w2 + 17'(k)) < cap17))
            begin
                sk = 3'(k);
            end
        end
        w3 = w2 + 17'(sk);

        o1     = f1 ? 3'd3 : 3'd0;
        o2     = o1 + (f2 ? l2 : 3'd0);
        n_data = {1'b0, o2} + {1'b0, sk};

        rel1 = '0;
        rel2 = '0;
        for (int i = 0; i < MAX_RES; i++)
        begin
            rel1 = 3'(i) - o1;
            rel2 = 3'(i) - o2;
            if (3'(i) < o1)
            begin
                q_data.bytes[i] = g1u.b[2'(i)];
            end
            else if (3'(i) < o2)
            begin
                q_data.bytes[i] = g2u.b[rel1[1:0]];
            end
            else if (4'(i) < n_data)
            begin
                q_data.bytes[i] = s_bytes[rel2[1:0]];
            end
            else
            begin
                q_data.bytes[i] = CH_NUL;
            end
        end
        q_data.count  = n_data + {3'b0, end_on};
        q_data.is_end = end_on;
        q_data.base   = wr_reg;

        q_push  = accept && (q_data.count != '0);
        wr_next = end_on ? '0 : w3[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_NORMAL;
            hex_reg  <= '0;
            dig_reg  <= '0;
            pend_reg <= '0;
            wr_reg   <= '0;
            cap_reg  <= CAP_RESET;
        end
        else
        begin
            if (accept)
            begin
                mode_reg <= mode_next;
                hex_reg  <= hex_next;
                dig_reg  <= dig_next;
                pend_reg <= pend_next;
                wr_reg   <= wr_next;
            end
            if (cfg_wen)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dbyte_reg[k] <= dbyte_next[k];
            end
        end
    end

endmodule

// File: design/jsu_back.sv
// ============================================================================
// jsu_back
// Result serializer: walks the head entry one result a cycle, unless the
// output is stalled, into the output register.
// ============================================================================
module jsu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  jsu_pkg::entry_t head,
    input  logic            q_empty,
    output logic            q_pop,
    jsu_out_if.source       result
);
    import jsu_pkg::*;

    logic [SLOT_W-1:0] idx_reg;
    logic              ov_reg;
    byte_t             byte_reg;
    logic              kind_reg;
    len_t              len_reg;
    logic              last_reg;

    logic              load, take, is_last, kind_c;
    len_t              len_c;

    assign result.valid      = ov_reg;
    assign result.out_byte   = byte_reg;
    assign result.kind       = kind_reg;
    assign result.out_length = len_reg;
    assign result.last       = last_reg;

    always_comb
    begin
        load    = !ov_reg || result.ready;
        take    = load && !q_empty;
        is_last = ({1'b0, idx_reg} == (head.count - 1'b1));
        kind_c  = is_last && head.is_end;
        // Data result i reports base+i+1; the end result reports base+data count
        len_c   = head.base + 16'(idx_reg) + {15'b0, !kind_c};
        q_pop   = take && is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg  <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            if (load)
            begin
                ov_reg <= !q_empty;
            end
            if (take)
            begin
                idx_reg <= is_last ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= head.bytes[idx_reg];
            kind_reg <= kind_c;
            len_reg  <= len_c;
            last_reg <= is_last;
        end
    end

endmodule

// File: sim/jsu_tb_pkg.sv
// ============================================================================
// jsu_tb_pkg
// Scoreboard for the JSON string unescaper: predicts the UTF-8 byte and
// end-of-string results of each transferred text byte and checks the
// results that come out against them in order.
// ============================================================================
package jsu_tb_pkg;

    import jsu_pkg::*;

    localparam byte_t CH_ZERO  = 8'h30;
    localparam byte_t CH_NINE  = 8'h39;
    localparam byte_t CH_LC_A  = 8'h61;
    localparam byte_t CH_LC_F  = 8'h66;
    localparam byte_t CH_LC_G  = 8'h67;
    localparam byte_t CH_UC_A  = 8'h41;
    localparam byte_t CH_UC_F  = 8'h46;
    localparam byte_t CH_SLASH = 8'h2F;

    localparam int unsigned CAP_RESET    = 256;
    localparam int          REPORT_LIMIT = 100;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [2:0] {
        MODE_TEXT,
        MODE_ESC,
        MODE_HEX,
        MODE_HI_WAIT,
        MODE_HI_BSLASH,
        MODE_HI_HEX
    } text_mode_t;

    typedef struct packed {
        byte_t out_byte;
        logic  kind;
        len_t  out_length;
        logic  last;
    } text_result_t;

    // -1 for a byte that is not a hex digit
    function automatic int hex_value_of(input byte_t c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c - CH_ZERO);
        if (c >= CH_LC_A && c <= CH_LC_F)
            return int'(c - CH_LC_A) + 10;
        if (c >= CH_UC_A && c <= CH_UC_F)
            return int'(c - CH_UC_A) + 10;
        return -1;
    endfunction

    class unescape_scoreboard;
        int unsigned  capacity;
        text_mode_t   mode;
        logic [15:0]  code_acc;
        int unsigned  digits;
        logic [15:0]  high_half;
        int unsigned  written;
        byte_t        digit_chars[4];
        text_result_t step_res[$];
        text_result_t expected[$];
        int           failures;

        function new();
            capacity  = CAP_RESET;
            mode      = MODE_TEXT;
            code_acc  = '0;
            digits    = 0;
            high_half = '0;
            written   = 0;
            failures  = 0;
            foreach (digit_chars[k])
                digit_chars[k] = CH_NUL;
        endfunction

        function void set_capacity(input len_t v);
            capacity = v;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void push_result(input byte_t b, input logic k);
            text_result_t r;
            if (step_res.size() >= MAX_RES)
                return;
            r.out_byte   = b;
            r.kind       = k;
            r.out_length = len_t'(written);
            r.last       = 1'b0;
            step_res.push_back(r);
        endfunction

        function void put_byte(input byte_t b);
            if (written + 1 >= capacity)
                return;
            written++;
            push_result(b, KIND_BYTE);
        endfunction

        // Encode one code point; the whole group is dropped if it does not fit
        function void put_code(input int unsigned cp);
            byte_t       g[4];
            int unsigned len;
            if (cp <= 'h7F)
            begin
                len  = 1;
                g[0] = byte_t'(cp);
            end
            else if (cp <= 'h7FF)
            begin
                len  = 2;
                g[0] = UTF8_LEAD2 | byte_t'(cp >> 6);
                g[1] = UTF8_CONT | byte_t'(cp & 'h3F);
            end
            else if (cp <= 'hFFFF)
            begin
                len  = 3;
                g[0] = UTF8_LEAD3 | byte_t'(cp >> 12);
                g[1] = UTF8_CONT | byte_t'((cp >> 6) & 'h3F);
                g[2] = UTF8_CONT | byte_t'(cp & 'h3F);
            end
            else
            begin
                len  = 4;
                g[0] = UTF8_LEAD4 | byte_t'((cp >> 18) & 'h07);
                g[1] = UTF8_CONT | byte_t'((cp >> 12) & 'h3F);
                g[2] = UTF8_CONT | byte_t'((cp >> 6) & 'h3F);
                g[3] = UTF8_CONT | byte_t'(cp & 'h3F);
            end
            if (written + len >= capacity)
                return;
            for (int k = 0; k < len; k++)
            begin
                written++;
                push_result(g[k], KIND_BYTE);
            end
        endfunction

        function void plain_text(input byte_t b);
            if (b == CH_NUL || b == CH_QUOTE)
            begin
                push_result(CH_NUL, KIND_END);
                written   = 0;
                mode      = MODE_TEXT;
                code_acc  = '0;
                digits    = 0;
                high_half = '0;
            end
            else if (b == CH_BSLASH)
                mode = MODE_ESC;
            else
                put_byte(b);
        endfunction

        function void escaped(input byte_t b);
            mode = MODE_TEXT;
            if (b == CH_NUL)
            begin
                put_byte(CH_BSLASH);
                plain_text(CH_NUL);
            end
            else if (b == CH_U)
            begin
                mode     = MODE_HEX;
                code_acc = '0;
                digits   = 0;
            end
            else
            begin
                case (b)
                    CH_N:    put_byte(CH_LF);
                    CH_T:    put_byte(CH_TAB);
                    CH_R:    put_byte(CH_CR);
                    CH_B:    put_byte(CH_BS);
                    CH_F:    put_byte(CH_FF);
                    default: put_byte(b);
                endcase
            end
        endfunction

        function void got_code(input logic [15:0] cp);
            code_acc = '0;
            digits   = 0;
            if (cp >= SUR_HI_LO && cp <= SUR_HI_HI)
            begin
                high_half = cp;
                mode      = MODE_HI_WAIT;
            end
            else
            begin
                mode = MODE_TEXT;
                put_code(cp);
            end
        endfunction

        function bit take_digit(input byte_t b, input int v);
            if (digits < 4)
                digit_chars[digits] = b;
            code_acc = {code_acc[11:0], 4'(v)};
            digits++;
            return digits >= 4;
        endfunction

        function void replay_digits();
            for (int k = 0; k < digits && k < 4; k++)
                put_byte(digit_chars[k]);
            digits   = 0;
            code_acc = '0;
        endfunction

        // Predict the results of one transferred text byte
        function void note_text(input byte_t b);
            int          v;
            logic [15:0] lo;
            v = hex_value_of(b);
            step_res.delete();
            case (mode)
                MODE_ESC:
                    escaped(b);
                MODE_HEX:
                    if (v >= 0)
                    begin
                        if (take_digit(b, v))
                            got_code(code_acc);
                    end
                    else
                    begin
                        mode = MODE_TEXT;
                        replay_digits();
                        plain_text(b);
                    end
                MODE_HI_WAIT:
                begin
                    mode = MODE_TEXT;
                    if (b == CH_BSLASH)
                        mode = MODE_HI_BSLASH;
                    else
                    begin
                        put_code(high_half);
                        plain_text(b);
                    end
                end
                MODE_HI_BSLASH:
                    if (b == CH_U)
                    begin
                        mode     = MODE_HI_HEX;
                        code_acc = '0;
                        digits   = 0;
                    end
                    else
                    begin
                        put_code(high_half);
                        escaped(b);
                    end
                MODE_HI_HEX:
                    if (v >= 0)
                    begin
                        if (take_digit(b, v))
                        begin
                            lo = code_acc;
                            if (lo >= SUR_LO_LO && lo <= SUR_LO_HI)
                            begin
                                mode     = MODE_TEXT;
                                code_acc = '0;
                                digits   = 0;
                                put_code(32'(SUPP_BASE)
                                         + ((32'(high_half) - 32'(SUR_HI_LO)) << 10)
                                         + (32'(lo) - 32'(SUR_LO_LO)));
                            end
                            else
                            begin
                                put_code(high_half);
                                got_code(lo);
                            end
                        end
                    end
                    else
                    begin
                        mode = MODE_TEXT;
                        put_code(high_half);
                        replay_digits();
                        plain_text(b);
                    end
                default:
                begin
                    mode = MODE_TEXT;
                    plain_text(b);
                end
            endcase
            if (step_res.size() > 0)
                step_res[step_res.size() - 1].last = 1'b1;
            foreach (step_res[k])
                expected.push_back(step_res[k]);
        endfunction

        function void report(input string what, input int unsigned exp_v,
                             input int unsigned act_v);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, what, exp_v, act_v);
        endfunction

        function void check_result(input byte_t ob, input logic k, input len_t len,
                                   input logic lst);
            text_result_t e;
            if (expected.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("%0t: unexpected result, expected none, actual %h/%0d/%0d/%0d",
                             $time, ob, k, len, lst);
                return;
            end
            e = expected.pop_front();
            if (ob !== e.out_byte)
                report("out_byte", e.out_byte, ob);
            if (k !== e.kind)
                report("kind", e.kind, k);
            if (len !== e.out_length)
                report("out_length", e.out_length, len);
            if (lst !== e.last)
                report("last", e.last, lst);
        endfunction
    endclass

endpackage

// File: sim/tb_top.sv
// ============================================================================
// tb_top
// Testbench for json_string_unescape_utf8_core: streams JSON string bodies
// (directed corner cases, then mostly well-formed random strings with some
// noise) under several output capacities, with random stalls on both
// channels, and checks every result against the scoreboard prediction.
// ============================================================================
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;
    import jsu_tb_pkg::*;

    // Extra cycles after the last expected result: queue plus output register
    localparam int DRAIN_SLACK = 16;
    // Slowest run is about 700 bytes, each with up to 7 results that may all
    // stall; the timeout leaves a wide margin over that.
    localparam int TIMEOUT_NS  = 12_000_000;
    localparam int ITEM_TARGET = 440;
    localparam int QUIET_AFTER = 360;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wen;
    len_t cfg_wdata;

    // No idling on either side once set
    bit quiet = 1'b0;
    int items_sent = 0;

    unescape_scoreboard sb = new();

    jsu_in_if  text_if();
    jsu_out_if result_if();

    json_string_unescape_utf8_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text_if),
        .result    (result_if),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Check outputs first: a result never belongs to a byte taken at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
                sb.check_result(result_if.out_byte, result_if.kind,
                                result_if.out_length, result_if.last);
            if (text_if.valid && text_if.ready)
                sb.note_text(text_if.text_byte);
        end
    end

    // Sink pacing: random stall bursts, and runs of open cycles between them
    initial
    begin : sink_pacing
        result_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    // Hard stop in case the block hangs
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // Present one byte, optionally after an idle burst, and hold it until transfer
    task automatic send_text(input byte_t b);
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            text_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        text_if.valid     <= 1'b1;
        text_if.text_byte <= b;
        @(posedge clk);
        while (!text_if.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Hold the sender until every expected result has come out
    task automatic drain_results();
        text_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        // margin past the last expected result before the sender goes on
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_capacity(input len_t v);
        drain_results();
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen <= 1'b0;
        sb.set_capacity(v);
    endtask

    function automatic byte_t hex_char(input logic [3:0] n);
        if (n < 10)
            return CH_ZERO + byte_t'(n);
        return ($urandom_range(0, 1) ? CH_UC_A : CH_LC_A) + byte_t'(n - 10);
    endfunction

    function automatic byte_t bad_hex_byte();
        byte_t b;
        do
            b = byte_t'($urandom_range(0, 255));
        while (hex_value_of(b) >= 0);
        return b;
    endfunction

    function automatic byte_t plain_byte();
        byte_t b;
        do
            b = byte_t'($urandom_range(1, 255));
        while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    // Character after a backslash, other than u and zero
    function automatic byte_t esc_char();
        byte_t b;
        case ($urandom_range(0, 9))
            0: b = CH_N;
            1: b = CH_T;
            2: b = CH_R;
            3: b = CH_B;
            4: b = CH_F;
            5: b = CH_QUOTE;
            6: b = CH_BSLASH;
            7: b = CH_SLASH;
            default:
                do
                    b = byte_t'($urandom_range(1, 255));
                while (b == CH_U);
        endcase
        return b;
    endfunction

    // Code point outside the surrogate range, spread over the UTF-8 lengths
    function automatic logic [15:0] plain_code();
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'($urandom_range(1, 'h7F));
            2: return 16'($urandom_range('h80, 'h7FF));
            3: return 16'($urandom_range('h800, SUR_HI_LO - 1));
            default: return 16'($urandom_range(SUR_LO_HI + 1, 'hFFFF));
        endcase
    endfunction

    function automatic logic [15:0] high_code();
        return 16'($urandom_range(SUR_HI_LO, SUR_HI_HI));
    endfunction

    function automatic logic [15:0] low_code();
        return 16'($urandom_range(SUR_LO_LO, SUR_LO_HI));
    endfunction

    task automatic send_uesc(input logic [15:0] cp);
        send_text(CH_BSLASH);
        send_text(CH_U);
        for (int k = 3; k >= 0; k--)
            send_text(hex_char(cp[k*4 +: 4]));
    endtask

    // \u followed by up to three digits and then a non-hex byte
    task automatic send_broken_uesc();
        int ndig;
        ndig = $urandom_range(0, 3);
        send_text(CH_BSLASH);
        send_text(CH_U);
        repeat (ndig) send_text(hex_char(4'($urandom_range(0, 15))));
        send_text(bad_hex_byte());
    endtask

    task automatic send_token();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            send_text(plain_byte());
        else if (sel < 50)
        begin
            send_text(CH_BSLASH);
            send_text(esc_char());
        end
        else if (sel < 62)
            send_uesc(plain_code());
        else if (sel < 72)
        begin
            send_uesc(high_code());
            send_uesc(low_code());
        end
        else if (sel < 76)
            send_uesc(low_code());
        else if (sel < 80)
            // unpaired high: whatever follows decides how it is flushed
            send_uesc(high_code());
        else if (sel < 83)
        begin
            // second high flushes the first, then gets its partner
            send_uesc(high_code());
            send_uesc(high_code());
            send_uesc(low_code());
        end
        else if (sel < 86)
        begin
            send_uesc(high_code());
            send_text(CH_BSLASH);
            send_text(esc_char());
        end
        else if (sel < 93)
        begin
            if ($urandom_range(0, 1))
                send_uesc(high_code());
            send_broken_uesc();
        end
        else if (sel < 97)
            send_text(byte_t'($urandom_range(0, 255)));
        else
        begin
            send_text(CH_BSLASH);
            send_text(CH_NUL);
        end
    endtask

    task automatic send_string();
        int ntok;
        ntok = $urandom_range(0, 8);
        repeat (ntok) send_token();
        if ($urandom_range(0, 4) == 0)
            send_text(CH_NUL);
        else
            send_text(CH_QUOTE);
    endtask

    function automatic len_t pick_capacity();
        case ($urandom_range(0, 4))
            0: return len_t'($urandom_range(1, 8));
            1: return len_t'($urandom_range(9, 48));
            2: return len_t'(CAP_RESET);
            3: return 16'hFFFF;
            default: return len_t'($urandom_range(1, 'hFFFF));
        endcase
    endfunction

    initial
    begin : stimulus
        int phase_end;
        rst_n             <= 1'b0;
        cfg_wen           <= 1'b0;
        cfg_wdata         <= '0;
        text_if.valid     <= 1'b0;
        text_if.text_byte <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset capacity.
        // Surrogate pair at the top of the range: U+10FFFF as four bytes.
        send_uesc(SUR_HI_HI);
        send_uesc(SUR_LO_HI);
        // Unpaired high whose next escape breaks after one digit: the high
        // goes out as three bytes, the digit replays, the bad byte is text.
        send_uesc(SUR_HI_LO);
        send_text(CH_BSLASH);
        send_text(CH_U);
        send_text(CH_ZERO);
        send_text(CH_LC_G);
        // Backslash then zero: literal backslash, then end of string
        send_text(CH_BSLASH);
        send_text(CH_NUL);

        // Capacity zero and one: nothing fits, the end result still comes
        write_capacity(16'd0);
        send_text(CH_LC_A);
        send_text(CH_QUOTE);
        write_capacity(16'd1);
        send_text(CH_LC_A);
        send_text(CH_QUOTE);

        // Random phases, each under its own capacity; the first at the maximum
        write_capacity(16'hFFFF);
        while (items_sent < ITEM_TARGET)
        begin
            phase_end = items_sent + $urandom_range(40, 70);
            if ($urandom_range(0, 5) == 0)
            begin
                // noise: any byte value, including broken escapes
                while (items_sent < phase_end)
                    send_text(byte_t'($urandom_range(0, 255)));
            end
            else
            begin
                while (items_sent < phase_end)
                    send_string();
            end
            if (items_sent >= QUIET_AFTER)
                quiet = 1'b1;
            write_capacity(pick_capacity());
        end

        drain_results();
        if (sb.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
design/jsu_pkg.sv
design/jsu_if.sv
design/jsu_queue.sv
design/jsu_front.sv
design/jsu_back.sv
design/json_string_unescape_utf8_core.sv
sim/jsu_tb_pkg.sv
sim/tb_top.sv
